// File: src/toroidal_delta_distance_bearing_defines.svh
// Assertion macros shared by the toroidal delta, distance and bearing RTL.
`ifndef TOROIDAL_DELTA_DISTANCE_BEARING_DEFINES_SVH
`define TOROIDAL_DELTA_DISTANCE_BEARING_DEFINES_SVH

`ifndef SYNTHESIS

// Generic clocked check, switched off while reset is asserted.
`define TDB_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Check that applies to the result held in the output register.
`define TDB_ASSERT_RES(label, prop, msg) \
    `TDB_ASSERT(label, clk, rst_n, res_valid |-> (prop), msg)

`else

`define TDB_ASSERT(label, clk_sig, rst_sig, prop, msg)

`define TDB_ASSERT_RES(label, prop, msg)

`endif

`endif

// File: src/tdb_pkg.sv
// Package with constants, types and helper functions of the toroidal distance and bearing block.
`timescale 1ns / 1ps

package tdb_pkg;

    // Field and register widths.
    localparam int COORD_W     = 16;
    localparam int PERIOD_W    = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int DELTA_W     = 16;
    localparam int DIFF_W      = 18;

    // Period limits.
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 17'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_CAP = 17'd65536;

    // Coordinate slots used by the remainder stages.
    localparam int COORD_NUM = 4;
    localparam int CRD_FX    = 0;
    localparam int CRD_SX    = 1;
    localparam int CRD_FY    = 2;
    localparam int CRD_SY    = 3;

    // Remainder unit: bits of each coordinate handled per stage.
    localparam int MOD_BITS_PER_STAGE = 4;
    localparam int MOD_STAGES         = COORD_W / MOD_BITS_PER_STAGE;

    // CORDIC vectoring.
    localparam int CORDIC_STEPS    = 16;
    localparam int ATAN_TABLE_LEN  = 24;
    localparam int CORDIC_ITERS    = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
                                                                     : ATAN_TABLE_LEN;
    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = (CORDIC_ITERS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    localparam int CORDIC_W        = 32;
    localparam int FRAC_BITS       = 12;
    localparam int XPAD_W          = CORDIC_W - COORD_W - FRAC_BITS;

    // Gain correction and rounding.
    localparam logic [31:0] GAIN_Q32      = 32'h9B74_EDA8;
    localparam int          PROD_W        = 63;
    localparam int          DIST_SHIFT    = 32 + FRAC_BITS;
    localparam logic [63:0] DIST_ROUND    = 64'd1 << (31 + FRAC_BITS);
    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [31:0] BEARING_ROUND = 32'h0000_8000;

    // Pipeline stage positions.
    localparam int ST_IN      = 0;
    localparam int ST_DIFF    = MOD_STAGES + 1;
    localparam int ST_DELTA   = ST_DIFF + 1;
    localparam int ST_ABS     = ST_DELTA + 1;
    localparam int ST_MUL     = ST_ABS + CORDIC_STAGES + 1;
    localparam int ST_OUT     = ST_MUL + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1
    } cfg_reg_t;

    // One CORDIC working vector: x, y and angle accumulator.
    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [CORDIC_W-1:0] z;
    } cordic_vec_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h2000_0000;
            1:  a = 32'h12E4_051E;
            2:  a = 32'h09FB_385B;
            3:  a = 32'h0511_11D4;
            4:  a = 32'h028B_0D43;
            5:  a = 32'h0145_D7E1;
            6:  a = 32'h00A2_F61E;
            7:  a = 32'h0051_7C55;
            8:  a = 32'h0028_BE53;
            9:  a = 32'h0014_5F2F;
            10: a = 32'h000A_2F98;
            11: a = 32'h0005_17CC;
            12: a = 32'h0002_8BE6;
            13: a = 32'h0001_45F3;
            14: a = 32'h0000_A2FA;
            15: a = 32'h0000_517D;
            16: a = 32'h0000_28BE;
            17: a = 32'h0000_145F;
            18: a = 32'h0000_0A30;
            19: a = 32'h0000_0518;
            20: a = 32'h0000_028C;
            21: a = 32'h0000_0146;
            22: a = 32'h0000_00A3;
            23: a = 32'h0000_0051;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

    // Clamp a written period into the supported range.
    function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] v);
        logic [PERIOD_W-1:0] p;
        if (v < PERIOD_MIN) begin
            p = PERIOD_MIN;
        end else if (v > PERIOD_CAP) begin
            p = PERIOD_CAP;
        end else begin
            p = v;
        end
        return p;
    endfunction

    // One restoring remainder step: shift in one dividend bit, subtract the period if it fits.
    function automatic logic [COORD_W-1:0] mod_step(input logic [COORD_W-1:0]  rem,
                                                    input logic                bit_in,
                                                    input logic [PERIOD_W-1:0] m);
        logic [PERIOD_W-1:0] t;
        logic [PERIOD_W-1:0] d;
        t = {rem, bit_in};
        d = t - m;
        return (t >= m) ? d[COORD_W-1:0] : t[COORD_W-1:0];
    endfunction

    // Fold a raw difference of two reduced coordinates into [-P/2, P/2).
    function automatic logic [DELTA_W-1:0] wrap_fix(input logic signed [DIFF_W-1:0] diff,
                                                    input logic [PERIOD_W-1:0]      m);
        logic [COORD_W-1:0]       h;
        logic [PERIOD_W-1:0]      upper;
        logic signed [DIFF_W-1:0] lo_lim;
        logic signed [DIFF_W-1:0] hi_lim;
        logic signed [DIFF_W-1:0] r;
        h      = m[PERIOD_W-1:1];
        upper  = m - {1'b0, h};
        lo_lim = -$signed({2'b00, h});
        hi_lim = $signed({1'b0, upper});
        if (diff < lo_lim) begin
            r = diff + $signed({1'b0, m});
        end else if (diff >= hi_lim) begin
            r = diff - $signed({1'b0, m});
        end else begin
            r = diff;
        end
        return r[DELTA_W-1:0];
    endfunction

    // One CORDIC vectoring iteration that drives y toward zero.
    function automatic cordic_vec_t cordic_iter(input cordic_vec_t v, input int i);
        logic [CORDIC_W-1:0] xs;
        logic [CORDIC_W-1:0] ys;
        cordic_vec_t         r;
        xs = $signed(v.x) >>> i;
        ys = $signed(v.y) >>> i;
        if (!v.y[CORDIC_W-1]) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + atan_turn(i);
        end else begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - atan_turn(i);
        end
        return r;
    endfunction

endpackage

// File: src/toroidal_delta_distance_bearing.sv
// Top level: wrapped position delta, Euclidean distance and bearing on a toroidal map.
//
//  Channel | Signals                                        | Transfer when
//  --------+------------------------------------------------+------------------------
//  pos     | pos_valid pos_ready first_x first_y second_x/y | pos_valid & pos_ready
//  res     | res_valid res_ready delta_x/y distance bearing | res_valid & res_ready
//          | out_of_range                                   |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | cfg_valid & cfg_ready
//
// Eighteen register stages: input, four remainder stages, difference, wrap, magnitude,
// eight CORDIC stages of two iterations each, gain multiply and output. One item per
// cycle while results are taken or an empty stage remains.
// Reset clears all stage valid bits and sets both periods to 65536.
// A stage holds only while it and every stage after it are full and the result is not
// taken, so bubbles close up and the input keeps flowing into empty stages.
`timescale 1ns / 1ps
`include "toroidal_delta_distance_bearing_defines.svh"

module toroidal_delta_distance_bearing (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pos_valid,
    output logic                              pos_ready,
    input  logic [tdb_pkg::COORD_W-1:0]       first_x,
    input  logic [tdb_pkg::COORD_W-1:0]       first_y,
    input  logic [tdb_pkg::COORD_W-1:0]       second_x,
    input  logic [tdb_pkg::COORD_W-1:0]       second_y,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic signed [tdb_pkg::DELTA_W-1:0] delta_x,
    output logic signed [tdb_pkg::DELTA_W-1:0] delta_y,
    output logic [15:0]                       distance,
    output logic [15:0]                       bearing,
    output logic                              out_of_range,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tdb_pkg::PERIOD_W-1:0]      cfg_data
);

    import tdb_pkg::*;

    // Configuration registers, stored already clamped.
    logic [PERIOD_W-1:0] period_w_reg;
    logic [PERIOD_W-1:0] period_w_next;
    logic [PERIOD_W-1:0] period_h_reg;
    logic [PERIOD_W-1:0] period_h_next;

    // Stage control.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    // Remainder stages; index 0 is the input stage.
    logic [COORD_W-1:0] msrc_reg  [0:MOD_STAGES][0:COORD_NUM-1];
    logic [COORD_W-1:0] msrc_next [0:MOD_STAGES][0:COORD_NUM-1];
    logic [COORD_W-1:0] mrem_reg  [0:MOD_STAGES][0:COORD_NUM-1];
    logic [COORD_W-1:0] mrem_next [0:MOD_STAGES][0:COORD_NUM-1];

    // Raw differences of reduced coordinates.
    logic signed [DIFF_W-1:0] diffx_reg;
    logic signed [DIFF_W-1:0] diffx_next;
    logic signed [DIFF_W-1:0] diffy_reg;
    logic signed [DIFF_W-1:0] diffy_next;

    // Wrapped deltas and the range flag travel with the item.
    logic [DELTA_W-1:0] dx_reg  [ST_DELTA:ST_OUT];
    logic [DELTA_W-1:0] dx_next [ST_DELTA:ST_OUT];
    logic [DELTA_W-1:0] dy_reg  [ST_DELTA:ST_OUT];
    logic [DELTA_W-1:0] dy_next [ST_DELTA:ST_OUT];
    logic [ST_OUT:0]    oor_reg;
    logic [ST_OUT:0]    oor_next;

    // CORDIC vectors; index 0 is the magnitude stage.
    cordic_vec_t cv_reg  [0:CORDIC_STAGES];
    cordic_vec_t cv_next [0:CORDIC_STAGES];

    // Gain product, quadrant angle and final results.
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [31:0]       q_reg;
    logic [31:0]       q_next;
    logic [15:0]       dist_reg;
    logic [15:0]       dist_next;
    logic [15:0]       bear_reg;
    logic [15:0]       bear_next;

    // Configuration port is always ready.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        period_w_next = period_w_reg;
        period_h_next = period_h_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_WIDTH:  period_w_next = clamp_period(cfg_data);
                REG_MAP_HEIGHT: period_h_next = clamp_period(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_w_reg <= PERIOD_CAP;
            period_h_reg <= PERIOD_CAP;
        end
        else
        begin
            period_w_reg <= period_w_next;
            period_h_reg <= period_h_next;
        end
    end

    // A stage moves when some stage at or after it is empty or the result is taken.
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_adv
        assign adv[s] = res_ready | ~(&vld_reg[NUM_STAGES-1:s]);
    end

    always_comb
    begin
        vld_next[ST_IN] = adv[ST_IN] ? pos_valid : vld_reg[ST_IN];
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            vld_next[s] = adv[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Datapath next values for every stage.
    always_comb
    begin
        logic [COORD_W-1:0]  rem_t;
        logic [COORD_W-1:0]  src_t;
        logic [PERIOD_W-1:0] per_t;
        logic [DELTA_W-1:0]  ax_t;
        logic [DELTA_W-1:0]  ay_t;
        cordic_vec_t         v_t;
        logic [30:0]         xc_t;
        logic [30:0]         zc_t;
        logic [63:0]         dsum_t;
        logic [31:0]         bsum_t;
        logic [19:0]         dwide_t;

        // Input stage and range check.
        msrc_next[ST_IN][CRD_FX] = first_x;
        msrc_next[ST_IN][CRD_SX] = second_x;
        msrc_next[ST_IN][CRD_FY] = first_y;
        msrc_next[ST_IN][CRD_SY] = second_y;
        for (int c = 0; c < COORD_NUM; c++)
        begin
            mrem_next[ST_IN][c] = '0;
        end
        oor_next[ST_IN] = ({1'b0, first_x} >= period_w_reg) ||
                          ({1'b0, second_x} >= period_w_reg) ||
                          ({1'b0, first_y} >= period_h_reg) ||
                          ({1'b0, second_y} >= period_h_reg);
        for (int s = 1; s <= ST_OUT; s++)
        begin
            oor_next[s] = oor_reg[s-1];
        end

        // Remainder stages: four restoring steps of each coordinate per stage.
        for (int s = 1; s <= MOD_STAGES; s++)
        begin
            for (int c = 0; c < COORD_NUM; c++)
            begin
                per_t = (c < CRD_FY) ? period_w_reg : period_h_reg;
                rem_t = mrem_reg[s-1][c];
                src_t = msrc_reg[s-1][c];
                for (int b = 0; b < MOD_BITS_PER_STAGE; b++)
                begin
                    rem_t = mod_step(rem_t, src_t[COORD_W-1], per_t);
                    src_t = {src_t[COORD_W-2:0], 1'b0};
                end
                mrem_next[s][c] = rem_t;
                msrc_next[s][c] = src_t;
            end
        end

        // Target minus origin on the reduced coordinates.
        diffx_next = $signed({2'b00, mrem_reg[MOD_STAGES][CRD_SX]}) -
                     $signed({2'b00, mrem_reg[MOD_STAGES][CRD_FX]});
        diffy_next = $signed({2'b00, mrem_reg[MOD_STAGES][CRD_SY]}) -
                     $signed({2'b00, mrem_reg[MOD_STAGES][CRD_FY]});

        // Wrap into the half-open range around zero.
        dx_next[ST_DELTA] = wrap_fix(diffx_reg, period_w_reg);
        dy_next[ST_DELTA] = wrap_fix(diffy_reg, period_h_reg);
        for (int s = ST_DELTA + 1; s <= ST_OUT; s++)
        begin
            dx_next[s] = dx_reg[s-1];
            dy_next[s] = dy_reg[s-1];
        end

        // Magnitudes scaled into the CORDIC fixed point format.
        ax_t = dx_reg[ST_DELTA][DELTA_W-1] ? (~dx_reg[ST_DELTA] + 16'd1) : dx_reg[ST_DELTA];
        ay_t = dy_reg[ST_DELTA][DELTA_W-1] ? (~dy_reg[ST_DELTA] + 16'd1) : dy_reg[ST_DELTA];
        cv_next[0].x = {{XPAD_W{1'b0}}, ax_t, {FRAC_BITS{1'b0}}};
        cv_next[0].y = {{XPAD_W{1'b0}}, ay_t, {FRAC_BITS{1'b0}}};
        cv_next[0].z = '0;

        // CORDIC stages, a fixed pair of iterations in each.
        for (int k = 1; k <= CORDIC_STAGES; k++)
        begin
            v_t = cv_reg[k-1];
            for (int j = 0; j < ITERS_PER_STAGE; j++)
            begin
                if ((k - 1) * ITERS_PER_STAGE + j < CORDIC_ITERS)
                begin
                    v_t = cordic_iter(v_t, (k - 1) * ITERS_PER_STAGE + j);
                end
            end
            cv_next[k] = v_t;
        end

        // Gain multiply and quadrant mapping of the clamped angle.
        v_t  = cv_reg[CORDIC_STAGES];
        xc_t = v_t.x[CORDIC_W-1] ? 31'd0 : v_t.x[30:0];
        prod_next = {32'd0, xc_t} * {31'd0, GAIN_Q32};
        if (v_t.z[CORDIC_W-1])
        begin
            zc_t = 31'd0;
        end
        else if (v_t.z > QUARTER_TURN)
        begin
            zc_t = QUARTER_TURN[30:0];
        end
        else
        begin
            zc_t = v_t.z[30:0];
        end
        if (dy_reg[ST_MUL-1] == '0)
        begin
            q_next = dx_reg[ST_MUL-1][DELTA_W-1] ? HALF_TURN : 32'd0;
        end
        else if (!dx_reg[ST_MUL-1][DELTA_W-1] && !dy_reg[ST_MUL-1][DELTA_W-1])
        begin
            q_next = {1'b0, zc_t};
        end
        else if (!dy_reg[ST_MUL-1][DELTA_W-1])
        begin
            q_next = HALF_TURN - {1'b0, zc_t};
        end
        else if (dx_reg[ST_MUL-1][DELTA_W-1])
        begin
            q_next = HALF_TURN + {1'b0, zc_t};
        end
        else
        begin
            q_next = 32'd0 - {1'b0, zc_t};
        end

        // Rounding, saturation and the 16-bit binary angle.
        dsum_t    = {1'b0, prod_reg} + DIST_ROUND;
        dwide_t   = dsum_t[63:DIST_SHIFT];
        dist_next = (|dwide_t[19:16]) ? 16'hFFFF : dwide_t[15:0];
        bsum_t    = q_reg + BEARING_ROUND;
        bear_next = bsum_t[31:16];
    end

    // Payload registers load whenever their stage moves.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= MOD_STAGES; s++)
        begin
            if (adv[s])
            begin
                msrc_reg[s] <= msrc_next[s];
                mrem_reg[s] <= mrem_next[s];
            end
        end
        for (int s = 0; s <= ST_OUT; s++)
        begin
            if (adv[s])
            begin
                oor_reg[s] <= oor_next[s];
            end
        end
        if (adv[ST_DIFF])
        begin
            diffx_reg <= diffx_next;
            diffy_reg <= diffy_next;
        end
        for (int s = ST_DELTA; s <= ST_OUT; s++)
        begin
            if (adv[s])
            begin
                dx_reg[s] <= dx_next[s];
                dy_reg[s] <= dy_next[s];
            end
        end
        for (int k = 0; k <= CORDIC_STAGES; k++)
        begin
            if (adv[ST_ABS + k])
            begin
                cv_reg[k] <= cv_next[k];
            end
        end
        if (adv[ST_MUL])
        begin
            prod_reg <= prod_next;
            q_reg    <= q_next;
        end
        if (adv[ST_OUT])
        begin
            dist_reg <= dist_next;
            bear_reg <= bear_next;
        end
    end

    // Ports.
    assign pos_ready    = adv[ST_IN];
    assign res_valid    = vld_reg[ST_OUT];
    assign delta_x      = dx_reg[ST_OUT];
    assign delta_y      = dy_reg[ST_OUT];
    assign distance     = dist_reg;
    assign bearing      = bear_reg;
    assign out_of_range = oor_reg[ST_OUT];

    // Checks.
    `TDB_ASSERT(a_stall_only_when_full, clk, rst_n, !pos_ready |-> (&vld_reg), "stall, free stage")
    `TDB_ASSERT_RES(a_bearing_east, (~|delta_y && !delta_x[15]) |-> ~|bearing, "east not zero")
    `TDB_ASSERT_RES(a_bearing_west, (~|delta_y && delta_x[15]) |-> bearing == 16'h8000, "west not pi")
    `TDB_ASSERT_RES(a_zero_distance, (~|delta_x && ~|delta_y) |-> ~|distance, "zero delta, distance")

endmodule

// File: tb/tb_toroidal_delta_distance_bearing.sv
// Testbench for the toroidal wrapped delta, distance and bearing block.
`timescale 1ns / 1ps

module tb_toroidal_delta_distance_bearing;

    // Pipeline depth from input transfer to result, and the run limit in cycles.
    localparam int LATENCY     = 17;
    localparam int CYCLE_LIMIT = 400000;

    // Fixed-point constants of the vectoring unit.
    localparam int          VEC_STEPS   = 16;
    localparam int          VEC_FRAC    = 12;
    localparam logic [63:0] LENGTH_GAIN = 64'h9B74_EDA8;
    localparam logic [63:0] LENGTH_HALF = 64'd1 << 43;
    localparam logic [63:0] TURN_HALF   = 64'h8000_0000;
    localparam logic [63:0] TURN_FULL   = 64'h1_0000_0000;
    localparam longint      QUARTER_CAP = 64'h4000_0000;
    localparam logic [16:0] PERIOD_RESET = 17'h10000;

    // Register indexes that address no register.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    // One predicted result.
    typedef struct packed {
        logic [15:0] delta_x;
        logic [15:0] delta_y;
        logic [15:0] distance;
        logic [15:0] bearing;
        logic        out_of_range;
    } range_bearing_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pos_valid = 1'b0;
    logic        pos_ready;
    logic [15:0] first_x = '0;
    logic [15:0] first_y = '0;
    logic [15:0] second_x = '0;
    logic [15:0] second_y = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [15:0] distance;
    logic [15:0] bearing;
    logic        out_of_range;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    // Arctangent of 2^-i, 2^32 units per turn.
    logic [31:0] atan_lut [0:23] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    // Shadow copies of the two period registers.
    logic [16:0] width_setting = PERIOD_RESET;
    logic [16:0] height_setting = PERIOD_RESET;

    range_bearing_t range_bearing_q[$];
    int error_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    toroidal_delta_distance_bearing dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pos_valid    (pos_valid),
        .pos_ready    (pos_ready),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .distance     (distance),
        .bearing      (bearing),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit: far above the slowest correct run of about 1200 items with stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side stalls at random at the current rate.
    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Print one line for every mismatch and count it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at result %0d: %s", result_count, what);
    endtask

    // A period setting below 2 acts as 2 and one above 65536 acts as 65536.
    function automatic longint effective_period(input logic [16:0] setting);
        longint p;
        p = setting;
        if (p < 2)
        begin
            p = 2;
        end
        if (p > 65536)
        begin
            p = 65536;
        end
        return p;
    endfunction

    // Shortest wrapped difference target - origin in [-P/2, P/2).
    function automatic longint wrap_offset(input longint origin, input longint target,
                                           input longint period);
        longint h;
        longint r;
        h = period >>> 1;
        r = (target - origin + h) % period;
        if (r < 0)
        begin
            r += period;
        end
        return r - h;
    endfunction

    // Expected deltas, rounded length and binary-angle bearing for one position pair.
    function automatic range_bearing_t predict_range_bearing(input logic [15:0] fx,
                                                             input logic [15:0] fy,
                                                             input logic [15:0] sx,
                                                             input logic [15:0] sy);
        longint         pw;
        longint         ph;
        longint         dx;
        longint         dy;
        longint         x;
        longint         y;
        longint         z;
        longint         xs;
        longint         ys;
        logic [63:0]    prod;
        logic [63:0]    length;
        logic [63:0]    turn;
        range_bearing_t r;
        pw = effective_period(width_setting);
        ph = effective_period(height_setting);
        r.out_of_range = (longint'(fx) >= pw) || (longint'(sx) >= pw) ||
                         (longint'(fy) >= ph) || (longint'(sy) >= ph);
        dx = wrap_offset(longint'(fx), longint'(sx), pw);
        dy = wrap_offset(longint'(fy), longint'(sy), ph);

        // Vectoring on the absolute differences, arithmetic shifts round toward minus infinity.
        x = (dx < 0 ? -dx : dx) * (64'sd1 << VEC_FRAC);
        y = (dy < 0 ? -dy : dy) * (64'sd1 << VEC_FRAC);
        z = 0;
        for (int i = 0; i < VEC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_lut[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_lut[i]);
            end
        end

        // Gain correction and round half up.
        if (x < 0)
        begin
            x = 0;
        end
        prod = x;
        prod = prod * LENGTH_GAIN + LENGTH_HALF;
        length = prod >> 44;
        r.distance = (length > 64'hFFFF) ? 16'hFFFF : length[15:0];

        // Clamp the quarter-turn angle and map it into its quadrant.
        if (z < 0)
        begin
            z = 0;
        end
        if (z > QUARTER_CAP)
        begin
            z = QUARTER_CAP;
        end
        if (dy == 0)
        begin
            turn = (dx >= 0) ? 64'd0 : TURN_HALF;
        end
        else if (dx >= 0 && dy > 0)
        begin
            turn = z;
        end
        else if (dx < 0 && dy > 0)
        begin
            turn = TURN_HALF - z;
        end
        else if (dx < 0)
        begin
            turn = TURN_HALF + z;
        end
        else
        begin
            turn = TURN_FULL - z;
        end
        turn = (turn + 64'h8000) >> 16;
        r.bearing = turn[15:0];
        r.delta_x = dx[15:0];
        r.delta_y = dy[15:0];
        return r;
    endfunction

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        range_bearing_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (range_bearing_q.size() == 0)
            begin
                report_mismatch("result transfer with no pending prediction");
            end
            else
            begin
                want = range_bearing_q.pop_front();
                if (delta_x !== want.delta_x)
                begin
                    report_mismatch($sformatf("delta_x got %0d want %0d",
                                              delta_x, $signed(want.delta_x)));
                end
                if (delta_y !== want.delta_y)
                begin
                    report_mismatch($sformatf("delta_y got %0d want %0d",
                                              delta_y, $signed(want.delta_y)));
                end
                if (distance !== want.distance)
                begin
                    report_mismatch($sformatf("distance got %0d want %0d",
                                              distance, want.distance));
                end
                if (bearing !== want.bearing)
                begin
                    report_mismatch($sformatf("bearing got %0d want %0d",
                                              bearing, want.bearing));
                end
                if (out_of_range !== want.out_of_range)
                begin
                    report_mismatch($sformatf("out_of_range got %0b want %0b",
                                              out_of_range, want.out_of_range));
                end
            end
            result_count++;
        end
    end

    // Send one position pair, with random idle cycles ahead of it, and predict its result.
    task automatic send_pair(input logic [15:0] fx, input logic [15:0] fy,
                             input logic [15:0] sx, input logic [15:0] sy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            pos_valid <= 1'b0;
        end
        @(negedge clk);
        pos_valid <= 1'b1;
        first_x   <= fx;
        first_y   <= fy;
        second_x  <= sx;
        second_y  <= sy;
        @(posedge clk);
        while (!pos_ready)
        begin
            @(posedge clk);
        end
        range_bearing_q.push_back(predict_range_bearing(fx, fy, sx, sy));
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        pos_valid <= 1'b0;
        while (range_bearing_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One configuration transfer; the shadow registers follow at the transfer edge.
    task automatic write_register(input logic [1:0] index, input logic [16:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index == tdb_pkg::REG_MAP_WIDTH)
        begin
            width_setting = data;
        end
        else if (index == tdb_pkg::REG_MAP_HEIGHT)
        begin
            height_setting = data;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wrap limits, zero vectors and all four quadrants at the reset periods.
    task automatic test_wrap_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd65535, 16'd65535);
        send_pair(16'd65535, 16'd65535, 16'd0, 16'd0);
        send_pair(16'd0, 16'd0, 16'd32767, 16'd0);
        send_pair(16'd0, 16'd0, 16'd32768, 16'd0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd32768);
        send_pair(16'd0, 16'd0, 16'd32768, 16'd32768);
        send_pair(16'd100, 16'd200, 16'd100, 16'd5000);
        send_pair(16'd0, 16'd0, 16'd1000, 16'd1000);
        send_pair(16'd0, 16'd0, 16'd64536, 16'd1000);
        send_pair(16'd0, 16'd0, 16'd64536, 16'd64536);
        send_pair(16'd0, 16'd0, 16'd1000, 16'd64536);
        send_pair(16'd40000, 16'd12345, 16'd7, 16'd65000);
        wait_idle();
    endtask

    // Periods below the minimum, above the cap, odd periods and writes to spare indexes.
    task automatic test_period_limits();
        write_register(tdb_pkg::REG_MAP_WIDTH, 17'd0);
        write_register(tdb_pkg::REG_MAP_HEIGHT, 17'd1);
        send_pair(16'd0, 16'd0, 16'd1, 16'd1);
        send_pair(16'd1, 16'd1, 16'd0, 16'd0);
        send_pair(16'd2, 16'd0, 16'd0, 16'd65535);
        wait_idle();

        // Spare indexes must leave both periods alone.
        write_register(REG_SPARE_A, 17'd5);
        write_register(REG_SPARE_B, 17'h1FFFF);
        send_pair(16'd1, 16'd0, 16'd0, 16'd1);
        wait_idle();

        write_register(tdb_pkg::REG_MAP_WIDTH, 17'h1FFFF);
        write_register(tdb_pkg::REG_MAP_HEIGHT, 17'd3);
        send_pair(16'd65535, 16'd2, 16'd0, 16'd0);
        send_pair(16'd0, 16'd3, 16'd0, 16'd0);
        wait_idle();

        write_register(tdb_pkg::REG_MAP_WIDTH, 17'd65535);
        write_register(tdb_pkg::REG_MAP_HEIGHT, 17'h10000);
        send_pair(16'd65535, 16'd0, 16'd0, 16'd0);
        send_pair(16'd65534, 16'd0, 16'd0, 16'd0);
        wait_idle();
    endtask

    // Random period setting, weighted toward the extremes.
    function automatic logic [16:0] pick_period();
        logic [16:0] p;
        case ($urandom_range(5))
            0: p = 17'h10000;
            1: p = 17'($urandom_range(16, 2));
            2: p = 17'($urandom_range(131071, 65537));
            3: p = 17'($urandom_range(1));
            default: p = 17'($urandom_range(65536, 2));
        endcase
        return p;
    endfunction

    // Mostly in-range coordinates, sometimes any 16-bit value.
    function automatic logic [15:0] pick_coord(input longint period);
        if ($urandom_range(9) == 0)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(32'(period - 1)));
    endfunction

    // Random pairs in chunks, each chunk under a fresh pair of periods.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        longint      pw;
        longint      ph;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] sx;
        logic [15:0] sy;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            wait_idle();
            write_register(tdb_pkg::REG_MAP_WIDTH, pick_period());
            write_register(tdb_pkg::REG_MAP_HEIGHT, pick_period());
            pw = effective_period(width_setting);
            ph = effective_period(height_setting);
            for (int n = 0; n < count / 4; n++)
            begin
                fx = pick_coord(pw);
                fy = pick_coord(ph);
                sx = pick_coord(pw);
                sy = pick_coord(ph);
                // Targets half a period away hit the wrap boundary exactly.
                if ($urandom_range(7) == 0 && longint'(fx) < pw && longint'(fy) < ph)
                begin
                    sx = 16'((longint'(fx) + (pw >>> 1)) % pw);
                    sy = 16'((longint'(fy) + (ph >>> 1)) % ph);
                end
                send_pair(fx, fy, sx, sy);
            end
        end
        wait_idle();
    endtask

    // Reset, directed tests, random traffic under three idle mixes, then the verdict.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_wrap_extremes();
        test_period_limits();
        test_random_traffic(26, 52, 400);
        test_random_traffic(52, 26, 400);
        test_random_traffic(0, 0, 400);

        wait_idle();
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
